### hw/rtl/whmv_pkg.sv
// Shared types and constants for the windowed history mean and variance block.
package whmv_pkg;

    localparam int WIN_W        = 11;
    localparam int START_W      = 10;
    localparam int SAMPLE_W     = 16;
    localparam int SAMPLE_MAX_W = 24;
    localparam int MEAN_W       = 24;
    localparam int VAR_W        = 39;
    localparam int CNT_OUT_W    = 11;
    localparam int FRAC_BITS    = 8;
    localparam int DVS_W        = 3 * WIN_W;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [VAR_W-1:0]  VAR_MAX  = {VAR_W{1'b1}};
    localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_valid;
        logic [WIN_W-1:0]           window_size;
        logic [START_W-1:0]         start_ago;
    } item_t;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_q8;
        logic [VAR_W-1:0]         variance_q8;
        logic [CNT_OUT_W-1:0]     used_count;
        logic                     window_error;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;
        logic query;
        logic load;
        logic reload;
        logic issue;
        logic div_start;
        logic div_sel_var;
        logic mean_cap;
        logic var_cap;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic w_zero;
        logic remain_zero;
        logic pipe_empty;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

### hw/rtl/whmv_ctrl.sv
// Controller state machine that sequences pushes, the two history passes and the divisions.
module whmv_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_cmd,
    output logic               item_stall,
    output whmv_pkg::dp_cmd_t  cmd,
    input  whmv_pkg::dp_stat_t stat
);
    import whmv_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_SETUP     = 11'b000_0000_0010,
        S_SUM       = 11'b000_0000_0100,
        S_SUM_DRAIN = 11'b000_0000_1000,
        S_SQ        = 11'b000_0001_0000,
        S_SQ_DRAIN  = 11'b000_0010_0000,
        S_DIVM_GO   = 11'b000_0100_0000,
        S_DIVM_WAIT = 11'b000_1000_0000,
        S_DIVV_GO   = 11'b001_0000_0000,
        S_DIVV_WAIT = 11'b010_0000_0000,
        S_FINISH    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Items are taken only while no query is in progress.
    assign item_stall = (state_reg != S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item_cmd == CMD_QUERY)
                    begin
                        cmd.query  = 1'b1;
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
            end
            S_SETUP:
            begin
                cmd.load   = 1'b1;
                state_next = stat.w_zero ? S_FINISH : S_SUM;
            end
            S_SUM:
            begin
                if (stat.remain_zero)
                    state_next = S_SUM_DRAIN;
                else
                    cmd.issue = 1'b1;
            end
            S_SUM_DRAIN:
            begin
                cmd.reload = 1'b1;
                if (stat.pipe_empty)
                    state_next = S_SQ;
            end
            S_SQ:
            begin
                if (stat.remain_zero)
                    state_next = S_SQ_DRAIN;
                else
                    cmd.issue = 1'b1;
            end
            S_SQ_DRAIN:
            begin
                if (stat.pipe_empty)
                    state_next = S_DIVM_GO;
            end
            S_DIVM_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVM_WAIT;
            end
            S_DIVM_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_cap = 1'b1;
                    state_next   = S_DIVV_GO;
                end
            end
            S_DIVV_GO:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_var = 1'b1;
                state_next      = S_DIVV_WAIT;
            end
            S_DIVV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.var_cap = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hw/rtl/whmv_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module whmv_div #(
    parameter int DVD_W = 73,
    parameter int DVS_W = 33
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int CW = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DVD_W-1:0] q_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             rem_ge;
    logic [DVS_W-1:0] rem_next;
    logic [DVD_W-1:0] q_next;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[DVD_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        rem_ge   = (rem_sh >= {1'b0, dvs_reg});
        rem_next = rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        q_next   = {q_reg[DVD_W-2:0], rem_ge};
    end

    // Step counter and completion flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### hw/rtl/whmv_dpath.sv
// Datapath: history memory, pointers, sum and square pipelines, divider and result register.
module whmv_dpath #(
    parameter int HISTORY_DEPTH = 1024,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  whmv_pkg::item_t     item,
    input  whmv_pkg::dp_cmd_t   cmd,
    output whmv_pkg::dp_stat_t  stat,
    output logic                result_valid,
    input  logic                result_stall,
    output whmv_pkg::result_t   result
);
    import whmv_pkg::*;

    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int WIDE_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam int S_W    = SAMPLE_BITS + CNT_W;
    localparam int M_W    = SAMPLE_BITS + WIDE_W;
    localparam int DW     = M_W + 1;
    localparam int L_W    = (M_W + 1) / 2;
    localparam int H_W    = M_W - L_W;
    localparam int SQ_W   = 2 * M_W;
    localparam int ACC_W  = SQ_W + CNT_W;
    localparam int DVD_W  = ACC_W + FRAC_BITS;
    localparam int EW     = WIDE_W + 1;
    localparam int PW     = AW + START_W + 1;
    localparam int WX_W   = SAMPLE_BITS + WIN_W + 1;

    // History store and read port.
    logic [SAMPLE_BITS:0] mem_arr [HISTORY_DEPTH];
    logic [SAMPLE_BITS:0] rd_data_reg;

    // Ring pointers and query span.
    logic [AW-1:0]      wp_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      base_addr_reg;
    logic [CNT_W-1:0]   remain_reg;
    logic [CNT_W-1:0]   base_cnt_reg;
    logic               pass2_reg;
    logic [WIN_W-1:0]   w_reg;
    logic [START_W-1:0] start_reg;
    logic [2*WIN_W-1:0] w2_reg;
    logic [DVS_W-1:0]   w3_reg;

    // Pipeline stage tags.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Accumulators and pipeline payload.
    logic signed [S_W-1:0]  sum_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic signed [WX_W-1:0] wx_reg;
    logic [M_W-1:0]         m_reg;
    logic [2*H_W-1:0]       phh_reg;
    logic [H_W+L_W-1:0]     phl_reg;
    logic [2*L_W-1:0]       pll_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [MEAN_W-1:0]      mean_reg;
    logic [VAR_W-1:0]       var_reg;
    logic                   out_valid_reg;
    result_t                out_data_reg;

    // Combinational helpers.
    logic [SAMPLE_MAX_W-1:0]       raw_ext;
    logic [SAMPLE_BITS-1:0]        new_sample;
    logic [EW-1:0]                 end_sum;
    logic [EW-1:0]                 end_lim;
    logic [CNT_W-1:0]              cnt_calc;
    logic [PW-1:0]                 addr_tmp;
    logic [AW-1:0]                 addr_calc;
    logic signed [SAMPLE_BITS-1:0] x_s;
    logic                          rd_ok;
    logic signed [WX_W-1:0]        wx_calc;
    logic signed [DW-1:0]          d_calc;
    logic [M_W-1:0]                m_calc;
    logic [H_W-1:0]                mh;
    logic [L_W-1:0]                ml;
    logic [2*H_W-1:0]              phh_calc;
    logic [H_W+L_W-1:0]            phl_calc;
    logic [2*L_W-1:0]              pll_calc;
    logic [SQ_W-1:0]               sq_calc;
    logic [2*WIN_W-1:0]            w2_calc;
    logic [DVS_W-1:0]              w3_calc;
    logic [S_W-1:0]                abs_sum;
    logic [DVD_W-1:0]              div_dividend;
    logic [DVS_W-1:0]              div_divisor;
    logic                          div_done;
    logic [DVD_W-1:0]              div_q;
    logic                          pipe_empty;
    logic                          out_free;

    // New sample: low SAMPLE_BITS of the port, read as signed.
    assign raw_ext    = {{(SAMPLE_MAX_W - SAMPLE_W){1'b0}}, item.sample};
    assign new_sample = raw_ext[SAMPLE_BITS-1:0];

    // Span of the query: entries start .. min(start + w, fill) - 1, newest first.
    always_comb
    begin
        end_sum   = EW'(start_reg) + EW'(w_reg);
        end_lim   = (end_sum > EW'(fill_reg)) ? EW'(fill_reg) : end_sum;
        cnt_calc  = (end_lim > EW'(start_reg)) ? CNT_W'(end_lim - EW'(start_reg)) : '0;
        addr_tmp  = PW'(wp_reg) + PW'(HISTORY_DEPTH - 1) - PW'(start_reg);
        addr_calc = (addr_tmp >= PW'(HISTORY_DEPTH)) ? AW'(addr_tmp - PW'(HISTORY_DEPTH))
                                                     : AW'(addr_tmp);
    end

    // Window powers for the variance divisor.
    assign w2_calc = w_reg * w_reg;
    assign w3_calc = w2_reg * w_reg;

    // Square pipeline arithmetic.
    always_comb
    begin
        x_s      = signed'(rd_data_reg[SAMPLE_BITS-1:0]);
        rd_ok    = rd_data_reg[SAMPLE_BITS];
        wx_calc  = signed'({1'b0, w_reg}) * x_s;
        d_calc   = DW'(wx_reg) - DW'(sum_reg);
        m_calc   = d_calc[DW-1] ? M_W'(-d_calc) : M_W'(d_calc);
        mh       = m_reg[M_W-1:L_W];
        ml       = m_reg[L_W-1:0];
        phh_calc = mh * mh;
        phl_calc = mh * ml;
        pll_calc = ml * ml;
        sq_calc  = (SQ_W'(phh_reg) << (2 * L_W)) + (SQ_W'(phl_reg) << (L_W + 1))
                 + SQ_W'(pll_reg);
    end

    // Divider operands: mean is |S|*256 / W, variance is acc*256 / W^3.
    always_comb
    begin
        abs_sum      = sum_reg[S_W-1] ? S_W'(-sum_reg) : S_W'(sum_reg);
        div_dividend = cmd.div_sel_var ? {acc_reg, {FRAC_BITS{1'b0}}}
                                       : DVD_W'({abs_sum, {FRAC_BITS{1'b0}}});
        div_divisor  = cmd.div_sel_var ? w3_reg : DVS_W'(w_reg);
    end

    whmv_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // History memory: write on push, registered read on issue.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem_arr[wp_reg] <= {item.sample_valid, new_sample};
        if (cmd.issue)
            rd_data_reg <= mem_arr[addr_reg];
    end

    // Pointers, span counters and stage tags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            fill_reg   <= '0;
            remain_reg <= '0;
            pass2_reg  <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            v5_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.push)
            begin
                wp_reg <= (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                if (fill_reg != CNT_W'(HISTORY_DEPTH))
                    fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.load)
            begin
                remain_reg <= cnt_calc;
                pass2_reg  <= 1'b0;
            end
            else if (cmd.reload)
            begin
                remain_reg <= base_cnt_reg;
                pass2_reg  <= 1'b1;
            end
            else if (cmd.issue)
            begin
                remain_reg <= remain_reg - 1'b1;
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg && pass2_reg && rd_ok;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Query fields, read address, accumulators and stage payload.
    always_ff @(posedge clk)
    begin
        if (cmd.query)
        begin
            w_reg     <= item.window_size;
            start_reg <= item.start_ago;
        end
        w2_reg <= w2_calc;
        w3_reg <= w3_calc;
        if (cmd.load)
        begin
            addr_reg      <= addr_calc;
            base_addr_reg <= addr_calc;
            base_cnt_reg  <= cnt_calc;
        end
        else if (cmd.reload)
        begin
            addr_reg <= base_addr_reg;
        end
        else if (cmd.issue)
        begin
            addr_reg <= (addr_reg == '0) ? AW'(HISTORY_DEPTH - 1) : addr_reg - 1'b1;
        end
        // First pass: sum and count of the valid samples.
        if (cmd.load)
        begin
            sum_reg <= '0;
            n_reg   <= '0;
        end
        else if (v1_reg && !pass2_reg && rd_ok)
        begin
            sum_reg <= sum_reg + S_W'(x_s);
            n_reg   <= n_reg + 1'b1;
        end
        // Second pass: sum of (W*x - S)^2.
        wx_reg  <= wx_calc;
        m_reg   <= m_calc;
        phh_reg <= phh_calc;
        phl_reg <= phl_calc;
        pll_reg <= pll_calc;
        sq_reg  <= sq_calc;
        if (cmd.load)
            acc_reg <= '0;
        else if (v5_reg)
            acc_reg <= acc_reg + ACC_W'(sq_reg);
        // Quotient capture with saturation.
        if (cmd.mean_cap)
        begin
            if (sum_reg[S_W-1])
                mean_reg <= (div_q > DVD_W'(MEAN_MIN)) ? MEAN_MIN : MEAN_W'(-div_q[MEAN_W-1:0]);
            else
                mean_reg <= (div_q > DVD_W'(MEAN_MAX)) ? MEAN_MAX : div_q[MEAN_W-1:0];
        end
        if (cmd.var_cap)
            var_reg <= (div_q > DVD_W'(VAR_MAX)) ? VAR_MAX : div_q[VAR_W-1:0];
        // Result register.
        if (cmd.out_load)
        begin
            if (stat.w_zero)
            begin
                out_data_reg.mean_q8      <= '0;
                out_data_reg.variance_q8  <= '0;
                out_data_reg.used_count   <= '0;
                out_data_reg.window_error <= 1'b1;
            end
            else
            begin
                out_data_reg.mean_q8      <= signed'(mean_reg);
                out_data_reg.variance_q8  <= var_reg;
                out_data_reg.used_count   <= CNT_OUT_W'(n_reg);
                out_data_reg.window_error <= 1'b0;
            end
        end
    end

    // Result valid: set on load, cleared when the transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    assign pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg);
    assign out_free   = !out_valid_reg || !result_stall;

    // Status to the controller.
    always_comb
    begin
        stat.w_zero      = (w_reg == '0);
        stat.remain_zero = (remain_reg == '0);
        stat.pipe_empty  = pipe_empty;
        stat.div_done    = div_done;
        stat.out_free    = out_free;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef NO_ASSERTIONS
    // The fill count never passes the depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("fill count above history depth");

    // Until the ring is full the write pointer equals the fill count.
    a_wp_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != CNT_W'(HISTORY_DEPTH)) |-> (CNT_W'(wp_reg) == fill_reg))
        else $error("write pointer out of step with fill count");

    // A read is issued only while entries of the span remain.
    a_issue_remain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (remain_reg != '0))
        else $error("read issued past the end of the span");

    // Divisions start only after both passes have drained.
    a_div_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> pipe_empty)
        else $error("division started with samples still in flight");
`endif

endmodule

### hw/rtl/windowed_history_mean_variance_top.sv
// Top level of the windowed history mean and variance block.
// A push does not stall the input; the next item can follow in the next cycle.
// A query makes two passes over the history memory at one read per cycle, then runs
// two divisions on a shared divider that yields one quotient bit per cycle
// (73 bits at the defaults).
// Reset clears the pointers, fill count and control; the history memory is not cleared.
module windowed_history_mean_variance_top #(
    parameter int HISTORY_DEPTH = 1024,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  whmv_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output whmv_pkg::result_t result
);
    import whmv_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencing.
    whmv_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (item.cmd),
        .item_stall (item_stall),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Storage and arithmetic.
    whmv_dpath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
